// ----- hdl/bgd_pkg.sv -----
// Package for the button gesture detector: payload and control structs,
// event codes, controller states and threshold helper functions.
// No dependencies.
`default_nettype none
package bgd_pkg;

    localparam logic [2:0] EV_PRESSED  = 3'd0;
    localparam logic [2:0] EV_RELEASED = 3'd1;
    localparam logic [2:0] EV_CLICKED  = 3'd2;
    localparam logic [2:0] EV_DOUBLE   = 3'd3;
    localparam logic [2:0] EV_HELD     = 3'd4;
    localparam logic [2:0] EV_REPEAT   = 3'd5;

    localparam logic [2:0] REG_DEBOUNCE = 3'd0;
    localparam logic [2:0] REG_WINDOW   = 3'd1;
    localparam logic [2:0] REG_DC_EN    = 3'd2;
    localparam logic [2:0] REG_HOLD_A   = 3'd3;
    localparam logic [2:0] REG_HOLD_B   = 3'd4;
    localparam logic [2:0] REG_REP_A    = 3'd5;
    localparam logic [2:0] REG_REP_B    = 3'd6;

    localparam logic [15:0] DEBOUNCE_DEFAULT = 16'd25;
    localparam logic [15:0] WINDOW_DEFAULT   = 16'd280;
    localparam int          MAX_LEVELS       = 4;

    typedef struct packed {
        logic [31:0] time_ms;
        logic        raw_level;
    } in_t;

    typedef struct packed {
        logic [2:0]  event_type;
        logic [23:0] ev_detail;
        logic        last_event;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_START, ST_EDGE, ST_RELEASE, ST_HOLD, ST_REP, ST_TIMEOUT, ST_FLUSH
    } state_t;

    typedef struct packed {
        logic       latch;
        logic       init;
        logic       raw_upd;
        logic       edge_apply;
        logic       rel_apply;
        logic       hold_skip;
        logic       hold_fire;
        logic       rep_clr;
        logic       rep_fire;
        logic       rep_next;
        logic       to_apply;
        logic       flush;
        logic       emit;
        logic [2:0] ev_type;
    } ctl_cmd_t;

    typedef struct packed {
        logic       started;
        logic       edge_hit;
        logic       edge_press;
        logic       rel_emit;
        logic [2:0] rel_type;
        logic       pressed_now;
        logic       hold_done;
        logic       hold_skip;
        logic       hold_fire;
        logic       rep_done;
        logic       rep_fire;
        logic       to_fire;
        logic       look_valid;
        logic       can_emit;
        logic       can_flush;
    } dp_sts_t;

    // Level i: register a, register b, zero beyond.
    function automatic logic [23:0] lvl_pick(input int i, input logic [23:0] a,
                                             input logic [23:0] b);
        logic [23:0] v;
        v = 24'd0;
        if (i == 0) begin
            v = a;
        end else if (i == 1) begin
            v = b;
        end
        return v;
    endfunction

    // Nonzero and not equal to an earlier level.
    function automatic logic lvl_used(input int i, input logic [23:0] a,
                                      input logic [23:0] b);
        logic [23:0] v;
        logic        u;
        v = lvl_pick(i, a, b);
        u = (v != 24'd0);
        for (int j = 0; j < MAX_LEVELS; j++) begin
            if (j < i && lvl_pick(j, a, b) == v) begin
                u = 1'b0;
            end
        end
        return u;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/bgd_datapath.sv -----
// Datapath: configuration registers, gesture state, repeat deadlines,
// one-beat lookahead event buffer and output register.
// Depends on bgd_pkg.
`default_nettype none
module bgd_datapath import bgd_pkg::*; #(
    parameter int HOLD_LEVELS     = 2,
    parameter int REPEAT_CHANNELS = 2,
    parameter int CATCHUP_LIMIT   = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire in_t         s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata,
    input  wire ctl_cmd_t    cmd,
    output dp_sts_t          sts
);
    localparam int HW  = $clog2(HOLD_LEVELS + 1);
    localparam int CW  = $clog2(REPEAT_CHANNELS + 1);
    localparam int CIW = (REPEAT_CHANNELS > 1) ? $clog2(REPEAT_CHANNELS) : 1;
    localparam int NW  = $clog2(CATCHUP_LIMIT + 1);

    logic [15:0] deb_reg, win_reg;
    logic        dce_reg;
    logic [23:0] thr_a_reg, thr_b_reg, iv_a_reg, iv_b_reg;
    logic [31:0] now_reg;
    logic        raw_in_reg;
    logic        started_reg, idle_reg, raw_seen_reg, stable_reg;
    logic        pressed_reg, hold_fired_reg, pend_reg;
    logic [31:0] rct_reg, press_time_reg, frt_reg, dl_reg;
    logic [HW-1:0] next_hold_reg;
    logic [31:0] due_reg [REPEAT_CHANNELS];
    logic [CW-1:0] chan_reg;
    logic [NW-1:0] n_reg;
    logic        look_valid_reg;
    logic [2:0]  look_type_reg;
    logic [23:0] look_detail_reg;
    out_t        out_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic [15:0] deb, win;
    logic [31:0] since_change, held, gap, dl_rel, to_diff, rep_diff;
    logic [23:0] thr_cur, iv_cur, gap_sat, detail;
    logic [CIW-1:0] ch_idx;
    logic        rel_double;
    logic        rel_emit;
    logic [2:0]  rel_type;

    assign deb     = (deb_reg == 16'd0) ? DEBOUNCE_DEFAULT : deb_reg;
    assign win     = (win_reg == 16'd0) ? WINDOW_DEFAULT : win_reg;
    assign ch_idx  = chan_reg[CIW-1:0];
    assign thr_cur = lvl_pick(int'(next_hold_reg), thr_a_reg, thr_b_reg);
    assign iv_cur  = lvl_pick(int'(chan_reg), iv_a_reg, iv_b_reg);
    assign since_change = now_reg - rct_reg;
    assign held    = now_reg - press_time_reg;
    assign gap     = now_reg - frt_reg;
    assign gap_sat = (|gap[31:24]) ? 24'hFFFFFF : gap[23:0];
    assign dl_rel  = dl_reg - now_reg;
    assign to_diff = now_reg - dl_reg;
    assign rep_diff = now_reg - due_reg[ch_idx];
    assign rel_double = !dl_rel[31];

    always_comb begin
        rel_emit = 1'b0;
        rel_type = EV_CLICKED;
        if (hold_fired_reg) begin
            rel_emit = 1'b0;
        end else if (!dce_reg) begin
            rel_emit = 1'b1;
        end else if (!pend_reg) begin
            rel_emit = 1'b0;
        end else if (rel_double) begin
            rel_emit = 1'b1;
            rel_type = EV_DOUBLE;
        end else begin
            rel_emit = 1'b1;
        end
    end

    assign sts.rel_emit    = rel_emit;
    assign sts.rel_type    = rel_type;
    assign sts.started     = started_reg;
    assign sts.edge_hit    = (raw_seen_reg != stable_reg) && (since_change >= {16'd0, deb});
    assign sts.edge_press  = (raw_seen_reg != idle_reg);
    assign sts.pressed_now = pressed_reg;
    assign sts.hold_done   = (next_hold_reg == HW'(HOLD_LEVELS));
    assign sts.hold_skip   = !lvl_used(int'(next_hold_reg), thr_a_reg, thr_b_reg);
    assign sts.hold_fire   = (held >= {8'd0, thr_cur});
    assign sts.rep_done    = (chan_reg == CW'(REPEAT_CHANNELS));
    assign sts.rep_fire    = lvl_used(int'(chan_reg), iv_a_reg, iv_b_reg)
                             && (n_reg < NW'(CATCHUP_LIMIT)) && !rep_diff[31];
    assign sts.to_fire     = !pressed_reg && dce_reg && pend_reg && !to_diff[31];
    assign sts.look_valid  = look_valid_reg;
    assign sts.can_emit    = !look_valid_reg || !out_valid_reg || m_ready;
    assign sts.can_flush   = !out_valid_reg || m_ready;

    always_comb begin
        case (cmd.ev_type)
            EV_DOUBLE: detail = gap_sat;
            EV_HELD:   detail = thr_cur;
            EV_REPEAT: detail = iv_cur;
            default:   detail = 24'd0;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if ((cmd.emit && look_valid_reg) || cmd.flush) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            now_reg    <= s_data.time_ms;
            raw_in_reg <= s_data.raw_level;
        end
        if (cmd.init) begin
            idle_reg       <= raw_in_reg;
            stable_reg     <= raw_in_reg;
            raw_seen_reg   <= raw_in_reg;
            pressed_reg    <= 1'b0;
            hold_fired_reg <= 1'b0;
            rct_reg        <= now_reg;
            press_time_reg <= now_reg;
            next_hold_reg  <= '0;
            pend_reg       <= 1'b0;
            frt_reg        <= '0;
            dl_reg         <= '0;
            for (int i = 0; i < REPEAT_CHANNELS; i++) begin
                due_reg[i] <= '0;
            end
        end
        if (cmd.raw_upd && raw_in_reg != raw_seen_reg) begin
            raw_seen_reg <= raw_in_reg;
            rct_reg      <= now_reg;
        end
        if (cmd.edge_apply) begin
            stable_reg  <= raw_seen_reg;
            pressed_reg <= sts.edge_press;
            if (sts.edge_press) begin
                press_time_reg <= now_reg;
                hold_fired_reg <= 1'b0;
                next_hold_reg  <= '0;
                for (int i = 0; i < REPEAT_CHANNELS; i++) begin
                    due_reg[i] <= now_reg + {8'd0, lvl_pick(i, iv_a_reg, iv_b_reg)};
                end
            end
        end
        if (cmd.rel_apply) begin
            if (hold_fired_reg || !dce_reg || (pend_reg && rel_double)) begin
                pend_reg <= 1'b0;
                frt_reg  <= '0;
                dl_reg   <= '0;
            end else begin
                pend_reg <= 1'b1;
                frt_reg  <= now_reg;
                dl_reg   <= now_reg + {16'd0, win};
            end
        end
        if (cmd.hold_skip) begin
            next_hold_reg <= next_hold_reg + HW'(1);
        end
        if (cmd.hold_fire) begin
            next_hold_reg  <= next_hold_reg + HW'(1);
            hold_fired_reg <= 1'b1;
        end
        if (cmd.rep_clr) begin
            chan_reg <= '0;
            n_reg    <= '0;
        end
        if (cmd.rep_fire) begin
            hold_fired_reg   <= 1'b1;
            due_reg[ch_idx]  <= due_reg[ch_idx] + {8'd0, iv_cur};
            n_reg            <= n_reg + NW'(1);
        end
        if (cmd.rep_next) begin
            chan_reg <= chan_reg + CW'(1);
            n_reg    <= '0;
        end
        if (cmd.to_apply) begin
            pend_reg <= 1'b0;
            frt_reg  <= '0;
            dl_reg   <= '0;
        end
        if (cmd.emit) begin
            look_type_reg   <= cmd.ev_type;
            look_detail_reg <= detail;
            if (look_valid_reg) begin
                out_reg <= '{event_type: look_type_reg, ev_detail: look_detail_reg,
                             last_event: 1'b0};
            end
        end
        if (cmd.flush) begin
            out_reg <= '{event_type: look_type_reg, ev_detail: look_detail_reg,
                         last_event: 1'b1};
        end

        if (!aresetn) begin
            deb_reg        <= DEBOUNCE_DEFAULT;
            win_reg        <= WINDOW_DEFAULT;
            dce_reg        <= 1'b0;
            thr_a_reg      <= '0;
            thr_b_reg      <= '0;
            iv_a_reg       <= '0;
            iv_b_reg       <= '0;
            started_reg    <= 1'b0;
            look_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.init) begin
                started_reg <= 1'b1;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DEBOUNCE: deb_reg   <= cfg_wdata[15:0];
                    REG_WINDOW:   win_reg   <= cfg_wdata[15:0];
                    REG_DC_EN:    dce_reg   <= cfg_wdata[0];
                    REG_HOLD_A:   thr_a_reg <= cfg_wdata;
                    REG_HOLD_B:   thr_b_reg <= cfg_wdata;
                    REG_REP_A:    iv_a_reg  <= cfg_wdata;
                    REG_REP_B:    iv_b_reg  <= cfg_wdata;
                    default:      ;
                endcase
                if (cfg_index <= REG_REP_B) begin
                    started_reg <= 1'b0;
                end
            end
            out_valid_reg <= out_valid_next;
            if (cmd.emit) begin
                look_valid_reg <= 1'b1;
            end
            if (cmd.flush) begin
                look_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

// ----- hdl/bgd_ctrl.sv -----
// Controller: walks one tick through debounce, release, hold, repeat,
// click timeout and flush, one event per cycle at most.
// Depends on bgd_pkg.
`default_nettype none
module bgd_ctrl import bgd_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire dp_sts_t sts,
    output ctl_cmd_t     cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.ev_type = EV_PRESSED;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (!sts.started) begin
                    cmd.init   = 1'b1;
                    state_next = ST_FLUSH;
                end else begin
                    cmd.raw_upd = 1'b1;
                    state_next  = ST_EDGE;
                end
            end
            ST_EDGE: begin
                if (!sts.edge_hit) begin
                    state_next = ST_HOLD;
                end else if (sts.can_emit) begin
                    cmd.edge_apply = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.ev_type    = sts.edge_press ? EV_PRESSED : EV_RELEASED;
                    state_next     = sts.edge_press ? ST_HOLD : ST_RELEASE;
                end
            end
            ST_RELEASE: begin
                if (!sts.rel_emit || sts.can_emit) begin
                    cmd.rel_apply = 1'b1;
                    cmd.emit      = sts.rel_emit;
                    cmd.ev_type   = sts.rel_type;
                    state_next    = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!sts.pressed_now) begin
                    state_next = ST_TIMEOUT;
                end else if (sts.hold_done) begin
                    cmd.rep_clr = 1'b1;
                    state_next  = ST_REP;
                end else if (sts.hold_skip) begin
                    cmd.hold_skip = 1'b1;
                end else if (sts.hold_fire) begin
                    if (sts.can_emit) begin
                        cmd.hold_fire = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.ev_type   = EV_HELD;
                    end
                end else begin
                    cmd.rep_clr = 1'b1;
                    state_next  = ST_REP;
                end
            end
            ST_REP: begin
                if (sts.rep_done) begin
                    state_next = ST_TIMEOUT;
                end else if (sts.rep_fire) begin
                    if (sts.can_emit) begin
                        cmd.rep_fire = 1'b1;
                        cmd.emit     = 1'b1;
                        cmd.ev_type  = EV_REPEAT;
                    end
                end else begin
                    cmd.rep_next = 1'b1;
                end
            end
            ST_TIMEOUT: begin
                if (!sts.to_fire) begin
                    state_next = ST_FLUSH;
                end else if (sts.can_emit) begin
                    cmd.to_apply = 1'b1;
                    cmd.emit     = 1'b1;
                    cmd.ev_type  = EV_CLICKED;
                    state_next   = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!sts.look_valid) begin
                    state_next = ST_IDLE;
                end else if (sts.can_flush) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/button_gesture_detector.sv -----
// Button gesture detector top level: controller plus datapath.
// A tick runs from accept to ready again: it latches the idle level if none is latched since
// reset or a configuration register write, else walks debounce, release, hold levels, repeat
// channels with their catch-up beats, click timeout and flush; beats per channel stop at CATCHUP_LIMIT.
// Throughput: one tick at a time; output stalls add cycles; the last beat loads on flush.
// Reset: synchronous active-low aresetn restores register defaults; next tick latches idle level.
`default_nettype none
module button_gesture_detector import bgd_pkg::*; #(
    parameter int HOLD_LEVELS     = 2,
    parameter int REPEAT_CHANNELS = 2,
    parameter int CATCHUP_LIMIT   = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_t         s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata
);
    ctl_cmd_t cmd;
    dp_sts_t  sts;

    bgd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bgd_datapath #(
        .HOLD_LEVELS     (HOLD_LEVELS),
        .REPEAT_CHANNELS (REPEAT_CHANNELS),
        .CATCHUP_LIMIT   (CATCHUP_LIMIT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    a_idle_flushed: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !sts.look_valid)
        else $error("lookahead beat pending while idle");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a second tick while busy");

    a_event_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.event_type <= EV_REPEAT))
        else $error("bad event code");

    a_plain_detail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.event_type == EV_PRESSED || m_data.event_type == EV_RELEASED
                     || m_data.event_type == EV_CLICKED)) |-> (m_data.ev_detail == 24'd0))
        else $error("nonzero detail on plain event");

endmodule
`default_nettype wire
